// ----- rtl/nst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_pkg
// Constants, coefficient table and types of the truncated nutation series.
// ----------------------------------------------------------------------------
package nst_pkg;

    localparam int TERM_COUNT   = 20;
    localparam int ROM_TERMS    = 20;
    localparam int TERMS_USED   = (TERM_COUNT < ROM_TERMS) ? TERM_COUNT : ROM_TERMS;
    localparam int TERM_W       = $clog2(ROM_TERMS);
    localparam int ANGLE_BITS   = 32;
    localparam int ARG_COUNT    = 5;
    localparam int ARG_W        = $clog2(ARG_COUNT);
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int TIME_W  = 40;
    localparam int NUT_W   = 32;
    localparam int VEC_W   = 33;
    localparam int RATE_W  = 42;
    localparam int HALF_W  = 21;

    localparam logic signed [VEC_W-1:0] CORDIC_START = 33'sd652032874;
    localparam logic signed [34:0] OFFSET_LONG = -35'sd1350;
    localparam logic signed [34:0] OFFSET_OBL  = 35'sd3880;

    localparam logic [127:0] UAS_PER_TURN = 128'd1296000000000;
    localparam logic [127:0] PI_Q61       = 128'h6487ED5110B4611A;

    localparam logic [63:0] PHASE_L  = 64'((128'd485868249036 << 64) / UAS_PER_TURN);
    localparam logic [63:0] PHASE_LP = 64'((128'd1287104793050 << 64) / UAS_PER_TURN);
    localparam logic [63:0] PHASE_F  = 64'((128'd335779526232 << 64) / UAS_PER_TURN);
    localparam logic [63:0] PHASE_D  = 64'((128'd1072260703690 << 64) / UAS_PER_TURN);
    localparam logic [63:0] PHASE_OM = 64'((128'd450160398036 << 64) / UAS_PER_TURN);

    localparam logic [RATE_W-1:0] RATE_L  =
        RATE_W'((128'd1717915923217800 << 30) / UAS_PER_TURN);
    localparam logic [RATE_W-1:0] RATE_LP =
        RATE_W'((128'd129596581048100 << 30) / UAS_PER_TURN);
    localparam logic [RATE_W-1:0] RATE_F  =
        RATE_W'((128'd1739527262847800 << 30) / UAS_PER_TURN);
    localparam logic [RATE_W-1:0] RATE_D  =
        RATE_W'((128'd1602961601209000 << 30) / UAS_PER_TURN);
    localparam logic [RATE_W-1:0] RATE_OM =
        RATE_W'((128'd6962890543100 << 30) / UAS_PER_TURN);

    localparam logic [ARG_W-1:0] ARG_OMEGA = ARG_W'(4);

    typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

    typedef enum logic [3:0] {
        S_IDLE,
        S_FUND,
        S_ROW,
        S_ANG,
        S_CINIT,
        S_CORD,
        S_MAC,
        S_FIN1,
        S_FIN2
    } nst_state_t;

    typedef struct packed {
        logic [4:0][2:0]    mult;
        logic signed [28:0] sp;
        logic signed [18:0] spt;
        logic signed [28:0] cp;
        logic signed [28:0] ce;
        logic signed [18:0] cet;
        logic signed [28:0] se;
    } term_row_t;

    function automatic atan_tab_t build_atan();
        atan_tab_t    tab;
        logic [63:0]  a;
        logic [63:0]  term;
        logic [127:0] wide;
        int           e;
        tab[0] = 64'd1 << 61;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            a = '0;
            for (int k = 0; k < 32; k++)
            begin
                e = i * (2 * k + 1);
                if (e <= 62)
                begin
                    term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                    if (k % 2 == 1)
                        a = a - term;
                    else
                        a = a + term;
                end
            end
            wide   = ({64'd0, a} << 62) / PI_Q61;
            tab[i] = wide[63:0];
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();

    function automatic logic [63:0] arg_phase(input logic [ARG_W-1:0] j);
        logic [63:0] v;
        case (j)
            3'd0:    v = PHASE_L;
            3'd1:    v = PHASE_LP;
            3'd2:    v = PHASE_F;
            3'd3:    v = PHASE_D;
            3'd4:    v = PHASE_OM;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [RATE_W-1:0] arg_rate(input logic [ARG_W-1:0] j);
        logic [RATE_W-1:0] v;
        case (j)
            3'd0:    v = RATE_L;
            3'd1:    v = RATE_LP;
            3'd2:    v = RATE_F;
            3'd3:    v = RATE_D;
            3'd4:    v = RATE_OM;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic term_row_t mk_row(
        input int m0, input int m1, input int m2, input int m3, input int m4,
        input int sp, input int spt, input int cp,
        input int ce, input int cet, input int se);
        term_row_t r;
        r.mult = {3'(m4), 3'(m3), 3'(m2), 3'(m1), 3'(m0)};
        r.sp   = 29'(sp);
        r.spt  = 19'(spt);
        r.cp   = 29'(cp);
        r.ce   = 29'(ce);
        r.cet  = 19'(cet);
        r.se   = 29'(se);
        return r;
    endfunction

    function automatic term_row_t rom_row(input logic [TERM_W-1:0] idx);
        term_row_t r;
        case (idx)
            5'd0:  r = mk_row( 0, 0, 0, 0, 1, -172064161, -174666,  33386,  92052331,  9086, 15377);
            5'd1:  r = mk_row( 0, 0, 2,-2, 2,  -13170906,   -1675, -13696,   5730336, -3015, -4587);
            5'd2:  r = mk_row( 0, 0, 2, 0, 2,   -2276413,    -234,   2796,    978459,  -485,  1374);
            5'd3:  r = mk_row( 0, 0, 0, 0, 2,    2074554,     207,   -698,   -897492,   470,  -291);
            5'd4:  r = mk_row( 0, 1, 0, 0, 0,    1475877,   -3633,  11817,     73871,  -184, -1924);
            5'd5:  r = mk_row( 0, 1, 2,-2, 2,    -516821,    1226,   -524,    224386,  -677,  -174);
            5'd6:  r = mk_row( 1, 0, 0, 0, 0,     711159,      73,   -872,     -6750,     0,   358);
            5'd7:  r = mk_row( 0, 0, 2, 0, 1,    -387298,    -367,    380,    200728,    18,   318);
            5'd8:  r = mk_row( 1, 0, 2, 0, 2,    -301461,     -36,    816,    129025,   -63,   367);
            5'd9:  r = mk_row( 0,-1, 2,-2, 2,     215829,    -494,    111,    -95929,   299,   132);
            5'd10: r = mk_row( 0, 0, 2,-2, 1,     128227,     137,    181,    -68982,    -9,    39);
            5'd11: r = mk_row(-1, 0, 2, 0, 2,     123457,      11,     19,    -53311,    32,    -4);
            5'd12: r = mk_row(-1, 0, 0, 2, 0,     156994,      10,   -168,     -1235,     0,    82);
            5'd13: r = mk_row( 1, 0, 0, 0, 1,      63110,      63,     27,    -33228,     0,    -9);
            5'd14: r = mk_row(-1, 0, 0, 0, 1,     -57976,     -63,   -189,     31429,     0,   -75);
            5'd15: r = mk_row(-1, 0, 2, 2, 2,     -59641,     -11,    149,     25543,   -11,    66);
            5'd16: r = mk_row( 1, 0, 2, 0, 1,     -51613,     -42,    129,     26366,     0,    78);
            5'd17: r = mk_row(-2, 0, 2, 0, 1,      45893,      50,     31,    -24236,   -10,    20);
            5'd18: r = mk_row( 0, 0, 0, 2, 0,      63384,      11,   -150,     -1220,     0,    29);
            5'd19: r = mk_row( 0, 0, 2, 2, 2,     -38571,      -1,    158,     16452,   -11,    68);
            default: r = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/nst_time_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_time_if
// Epoch word channel: valid, ready and the time in Julian centuries.
// ----------------------------------------------------------------------------
interface nst_time_if;
    logic              valid;
    logic              ready;
    logic signed [39:0] time_centuries;

    modport source (output valid, output time_centuries, input ready);
    modport sink   (input valid, input time_centuries, output ready);
endinterface

// ----- rtl/nst_nut_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_nut_if
// Nutation word channel: valid, ready, longitude and obliquity.
// ----------------------------------------------------------------------------
interface nst_nut_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] nutation_longitude;
    logic signed [31:0] nutation_obliquity;

    modport source (output valid, output nutation_longitude, output nutation_obliquity,
                    input ready);
    modport sink   (input valid, input nutation_longitude, input nutation_obliquity,
                    output ready);
endinterface

// ----- rtl/nutation_series_20_term_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nutation_series_20_term_unit
// Truncated luni-solar nutation series: fundamental arguments, iterative
// CORDIC per term and a multiply-accumulate into longitude and obliquity.
// ----------------------------------------------------------------------------
// channel   | dir | word
// time_in   | in  | time_centuries (Q5.34 centuries)
// nut_out   | out | nutation_longitude, nutation_obliquity (0.1 uas)
//
// After a word is accepted, the unit builds the five arguments into the
// argument RAM, then per term runs a row fetch, 5 argument reads, quadrant
// setup, 30 CORDIC steps and the multiply-accumulate into the longitude and
// obliquity sums, then rounds, and ready returns in the cycle after.
// A new word is taken only once ready has returned.
// Reset clears the sequencer and the output valid; no clearing pass.
// A waiting result does not block the next epoch word; it holds that word in
// the final rounding cycle until the output register frees.
// ----------------------------------------------------------------------------
module nutation_series_20_term_unit
    import nst_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    nst_time_if.sink       time_in,
    nst_nut_if.source      nut_out
);

    localparam logic [2:0] P_SP = 3'd0;
    localparam logic [2:0] P_AL = 3'd1;
    localparam logic [2:0] P_CP = 3'd2;
    localparam logic [2:0] P_CE = 3'd3;
    localparam logic [2:0] P_AO = 3'd4;
    localparam logic [2:0] P_SE = 3'd5;
    localparam logic [2:0] P_END = 3'd6;

    nst_state_t state_reg, state_next;

    logic signed [TIME_W-1:0] ts_reg;
    logic [ARG_W-1:0]         idx_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [TERM_W-1:0]        term_reg;
    logic [2:0]               mac_reg;

    logic [63:0]              fund_mem [ARG_COUNT];
    logic [63:0]              fund_rd_reg;
    logic [ARG_W-1:0]         rd_addr;

    term_row_t                row_reg;
    logic signed [61:0]       tprod_reg;
    logic [63:0]              fsum_reg;
    logic [63:0]              ang_reg;
    logic signed [31:0]       al_reg;
    logic signed [31:0]       ao_reg;

    logic signed [VEC_W-1:0]  x_reg;
    logic signed [VEC_W-1:0]  y_reg;
    logic [63:0]              z_reg;

    logic signed [63:0]       vprod_reg;
    logic signed [63:0]       acc_l_reg;
    logic signed [63:0]       acc_o_reg;
    logic signed [33:0]       rl_reg;
    logic signed [33:0]       ro_reg;

    logic                     out_valid_reg;
    logic signed [NUT_W-1:0]  out_long_reg;
    logic signed [NUT_W-1:0]  out_obl_reg;

    logic                     in_ready;
    logic                     slot_free;
    logic                     fin_load;

    logic signed [21:0]       ta;
    logic [RATE_W-1:0]        rate;
    logic signed [63:0]       tprod_ext;
    logic [63:0]              mterm;
    logic [63:0]              zt;
    logic signed [VEC_W-1:0]  dx;
    logic signed [VEC_W-1:0]  dy;
    logic signed [31:0]       va;
    logic signed [VEC_W-1:0]  vb;
    logic signed [63:0]       addend;
    logic [2:0]               pidx;
    logic signed [63:0]       rnd_l;
    logic signed [63:0]       rnd_o;

    function automatic logic signed [NUT_W-1:0] sat32(input logic signed [34:0] v);
        logic signed [NUT_W-1:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sx29(input logic signed [28:0] v);
        return {{3{v[28]}}, v};
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (time_in.valid)
                    state_next = S_FUND;
            S_FUND:
                if (step_reg == STEP_W'(2) && idx_reg == ARG_OMEGA)
                    state_next = S_ROW;
            S_ROW:
                state_next = S_ANG;
            S_ANG:
                if (idx_reg == ARG_OMEGA)
                    state_next = S_CINIT;
            S_CINIT:
                state_next = S_CORD;
            S_CORD:
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = S_MAC;
            S_MAC:
                if (mac_reg == P_END)
                begin
                    if (term_reg == TERM_W'(TERMS_USED - 1))
                        state_next = S_FIN1;
                    else
                        state_next = S_ROW;
                end
            S_FIN1:
                state_next = S_FIN2;
            S_FIN2:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        slot_free = !out_valid_reg || nut_out.ready;
        in_ready  = (state_reg == S_IDLE);
        fin_load  = (state_reg == S_FIN2) && slot_free;
    end

    assign time_in.ready              = in_ready;
    assign nut_out.valid              = out_valid_reg;
    assign nut_out.nutation_longitude = out_long_reg;
    assign nut_out.nutation_obliquity = out_obl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (nut_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath operand selection
    always_comb
    begin
        rate = arg_rate(idx_reg);
        if (state_reg == S_ANG)
            ta = {{3{row_reg.spt[18]}}, row_reg.spt};
        else if (step_reg == STEP_W'(0))
            ta = $signed({1'b0, rate[HALF_W-1:0]});
        else
            ta = $signed({1'b0, rate[RATE_W-1:HALF_W]});
        if (state_reg == S_ANG && idx_reg == ARG_W'(1))
            ta = {{3{row_reg.cet[18]}}, row_reg.cet};

        tprod_ext = {{2{tprod_reg[61]}}, tprod_reg};

        if (state_reg == S_ANG && idx_reg != ARG_OMEGA)
            rd_addr = idx_reg + ARG_W'(1);
        else
            rd_addr = '0;

        case ($signed(row_reg.mult[idx_reg]))
            3'sd1:   mterm = fund_rd_reg;
            3'sd2:   mterm = fund_rd_reg << 1;
            -3'sd1:  mterm = -fund_rd_reg;
            -3'sd2:  mterm = -(fund_rd_reg << 1);
            default: mterm = '0;
        endcase

        zt = {ang_reg[63 -: ANGLE_BITS], {(64 - ANGLE_BITS){1'b0}}};

        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;

        case (mac_reg)
            P_SP:    begin va = sx29(row_reg.sp); vb = y_reg; end
            P_AL:    begin va = al_reg;            vb = y_reg; end
            P_CP:    begin va = sx29(row_reg.cp); vb = x_reg; end
            P_CE:    begin va = sx29(row_reg.ce); vb = x_reg; end
            P_AO:    begin va = ao_reg;            vb = x_reg; end
            P_SE:    begin va = sx29(row_reg.se); vb = y_reg; end
            default: begin va = '0;                vb = '0;    end
        endcase

        pidx = mac_reg - 3'd1;
        if (pidx == P_AL || pidx == P_AO)
            addend = vprod_reg >>> 8;
        else
            addend = vprod_reg;

        rnd_l = acc_l_reg + 64'sd536870912;
        rnd_o = acc_o_reg + 64'sd536870912;
    end

    // argument RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FUND && step_reg == STEP_W'(2))
        begin
            if (idx_reg == ARG_OMEGA)
                fund_mem[idx_reg] <= fsum_reg - 64'(tprod_ext <<< HALF_W);
            else
                fund_mem[idx_reg] <= fsum_reg + 64'(tprod_ext <<< HALF_W);
        end
        fund_rd_reg <= fund_mem[rd_addr];
    end

    // coefficient ROM: registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROW)
            row_reg <= rom_row(term_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (time_in.valid)
                begin
                    ts_reg    <= time_in.time_centuries;
                    idx_reg   <= '0;
                    step_reg  <= '0;
                    term_reg  <= '0;
                    acc_l_reg <= '0;
                    acc_o_reg <= '0;
                end
            end
            S_FUND:
            begin
                tprod_reg <= 62'(ta * ts_reg);
                if (step_reg == STEP_W'(1))
                begin
                    if (idx_reg == ARG_OMEGA)
                        fsum_reg <= arg_phase(idx_reg) - tprod_ext;
                    else
                        fsum_reg <= arg_phase(idx_reg) + tprod_ext;
                end
                if (step_reg == STEP_W'(2))
                begin
                    step_reg <= '0;
                    idx_reg  <= idx_reg + ARG_W'(1);
                end
                else
                    step_reg <= step_reg + STEP_W'(1);
            end
            S_ROW:
            begin
                idx_reg <= '0;
                ang_reg <= '0;
            end
            S_ANG:
            begin
                ang_reg <= ang_reg + mterm;
                if (idx_reg == ARG_W'(0) || idx_reg == ARG_W'(1))
                    tprod_reg <= 62'(ta * ts_reg);
                if (idx_reg == ARG_W'(1))
                    al_reg <= tprod_reg[57:26];
                if (idx_reg == ARG_W'(2))
                    ao_reg <= tprod_reg[57:26];
                idx_reg <= idx_reg + ARG_W'(1);
            end
            S_CINIT:
            begin
                case (zt[63:62])
                    2'd0:    begin x_reg <= CORDIC_START;  y_reg <= '0;            end
                    2'd1:    begin x_reg <= '0;            y_reg <= CORDIC_START;  end
                    2'd2:    begin x_reg <= -CORDIC_START; y_reg <= '0;            end
                    default: begin x_reg <= '0;            y_reg <= -CORDIC_START; end
                endcase
                z_reg    <= {2'b00, zt[61:0]};
                step_reg <= '0;
            end
            S_CORD:
            begin
                if (!z_reg[63])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - ATAN_TAB[step_reg];
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + ATAN_TAB[step_reg];
                end
                step_reg <= step_reg + STEP_W'(1);
                mac_reg  <= P_SP;
            end
            S_MAC:
            begin
                vprod_reg <= 64'(va * vb);
                if (mac_reg != P_SP)
                begin
                    if (pidx == P_SP || pidx == P_AL || pidx == P_CP)
                        acc_l_reg <= acc_l_reg + addend;
                    else
                        acc_o_reg <= acc_o_reg + addend;
                end
                if (mac_reg == P_END)
                    term_reg <= term_reg + TERM_W'(1);
                mac_reg <= mac_reg + 3'd1;
            end
            S_FIN1:
            begin
                rl_reg <= rnd_l[63:30];
                ro_reg <= rnd_o[63:30];
            end
            S_FIN2:
            begin
                if (slot_free)
                begin
                    out_long_reg <= sat32({rl_reg[33], rl_reg} + OFFSET_LONG);
                    out_obl_reg  <= sat32({ro_reg[33], ro_reg} + OFFSET_OBL);
                end
            end
            default:
            begin
                idx_reg <= '0;
            end
        endcase
    end

endmodule
